// ----- src/sfat_pkg.sv -----
// Shared types and constants of the spin-flip acceptance table.
package sfat_pkg;

	localparam int T_W    = 24;   // temperature width
	localparam int A_W    = 19;   // |J| * |S| magnitude
	localparam int Q_W    = 35;   // scaled exponent x in Q.30, below 32.0
	localparam int K_W    = 6;    // whole multiples of ln2
	localparam int R_W    = 30;   // remainder below ln2 in Q.30
	localparam int TERM_W = 31;   // series term, up to 1.0 in Q.30
	localparam int SUM_W  = 33;   // signed series sum
	localparam int IDX_W  = 3;
	localparam int NTERMS = 14;
	localparam int CFG_W  = 16;

	localparam logic [Q_W-1:0] LN2_Q30 = 35'd744261118;
	localparam logic [TERM_W-1:0] Q30_ONE = 31'h4000_0000;

	localparam logic [IDX_W-1:0] LAST_SQUARE  = 3'd4;
	localparam logic [IDX_W-1:0] LAST_CUBIC   = 3'd6;
	localparam logic [IDX_W-1:0] LAST_CLUSTER = 3'd0;

	localparam logic [1:0] MODE_CUBIC = 2'd1;
	localparam int MODE_CLUSTER_BIT = 1;

	localparam logic REG_COUPLING = 1'b0;
	localparam logic REG_MODE     = 1'b1;

	localparam logic signed [4:0] SUM_SQUARE [5] = '{5'sd8, 5'sd4, 5'sd0, -5'sd4, -5'sd8};
	localparam logic signed [4:0] SUM_CUBIC [7] =
		'{5'sd12, 5'sd8, 5'sd4, 5'sd0, -5'sd4, -5'sd8, -5'sd12};

	typedef enum logic [1:0] {
		FIX_NONE,
		FIX_ONE,
		FIX_ZERO,
		FIX_ZERO_CLAMP
	} fix_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic             last;
		logic             cluster;
		logic             under;
		fix_t             fix;
	} meta_t;

	typedef struct packed {
		logic             vld;
		meta_t            meta;
		logic [T_W-1:0]   t;
		logic [A_W-1:0]   a;
		logic [T_W-1:0]   rem;
		logic [Q_W-1:0]   q;
	} div_t;

	typedef struct packed {
		logic             vld;
		meta_t            meta;
		logic [Q_W-1:0]   y;
		logic [K_W-1:0]   k;
	} ln2_t;

	typedef struct packed {
		logic                    vld;
		meta_t                   meta;
		logic [K_W-1:0]          k;
		logic [R_W-1:0]          r;
		logic [TERM_W-1:0]       term;
		logic signed [SUM_W-1:0] sum;
	} term_t;

endpackage

// ----- src/sfat_if.sv -----
// Channel interfaces: temperature words in, probability words out.
interface sfat_temp_if;
	logic        valid;
	logic        ready;
	logic [23:0] temperature;
	modport source (output valid, output temperature, input ready);
	modport sink (input valid, input temperature, output ready);
endinterface

interface sfat_prob_if #(parameter int PROB_W = 17);
	logic              valid;
	logic              ready;
	logic [2:0]        entry_index;
	logic [PROB_W-1:0] probability;
	logic              last;
	logic              clamped;
	modport source (output valid, output entry_index, output probability, output last,
		output clamped, input ready);
	modport sink (input valid, input entry_index, input probability, input last,
		input clamped, output ready);
endinterface

// ----- src/sfat_div_cell.sv -----
// One restoring-division cell: produces one quotient bit of A * 2^s / T.
module sfat_div_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           din,
	input  sfat_pkg::div_t d,
	output sfat_pkg::div_t q
);
	import sfat_pkg::*;

	logic [T_W:0] r2;
	logic [T_W:0] diff;
	logic         ge;
	div_t         nx;

	always_comb begin
		r2   = {d.rem, din};
		diff = r2 - {1'b0, d.t};
		ge   = r2 >= {1'b0, d.t};
		nx   = d;
		nx.rem = ge ? diff[T_W-1:0] : r2[T_W-1:0];
		nx.q   = {d.q[Q_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= nx;
		end
	end
endmodule

// ----- src/sfat_ln2_cell.sv -----
// One cell of the split y = k*ln2 + r: tests and removes ln2 << B.
module sfat_ln2_cell #(
	parameter int B = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  sfat_pkg::ln2_t d,
	output sfat_pkg::ln2_t q
);
	import sfat_pkg::*;

	localparam logic [Q_W-1:0] STEP = LN2_Q30 << B;

	logic ge;
	ln2_t nx;

	always_comb begin
		ge   = d.y >= STEP;
		nx   = d;
		nx.y = ge ? d.y - STEP : d.y;
		nx.k = {d.k[K_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q <= '0;
		end else if (en) begin
			q <= nx;
		end
	end
endmodule

// ----- src/sfat_term_cell.sv -----
// One Taylor term of exp(-r): term = floor(floor(term*r / 2^30) / N), added with sign.
module sfat_term_cell #(
	parameter int N = 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  sfat_pkg::term_t d,
	output sfat_pkg::term_t q
);
	import sfat_pkg::*;

	// floor(2^32 / N); estimate is low by at most one
	localparam logic [32:0] RECIP = 33'((64'd1 << 32) / N);
	localparam logic [R_W-1:0] NV = R_W'(N);

	term_t                   t_s1;
	logic [TERM_W+R_W-1:0]   prod_s1;
	term_t                   t_s2;
	logic [R_W-1:0]          x_s2;
	logic [R_W+32:0]         xm_s2;

	logic [R_W-1:0] x;
	logic [R_W-1:0] q0;
	logic [R_W-1:0] rem;
	logic [R_W-1:0] qv;
	term_t          nx;

	always_comb begin
		x   = prod_s1[R_W+R_W-1:R_W];
		q0  = R_W'(xm_s2[R_W+32:32]);
		rem = x_s2 - R_W'(q0 * NV);
		qv  = (rem >= NV) ? q0 + R_W'(1) : q0;
		nx      = t_s2;
		nx.term = TERM_W'(qv);
		if (N % 2 == 1) begin
			nx.sum = t_s2.sum - SUM_W'(qv);
		end else begin
			nx.sum = t_s2.sum + SUM_W'(qv);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_s1 <= '0;
			t_s2 <= '0;
			q    <= '0;
		end else if (en) begin
			t_s1 <= d;
			t_s2 <= t_s1;
			q    <= nx;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= (TERM_W+R_W)'(d.term) * (TERM_W+R_W)'(d.r);
			x_s2    <= x;
			xm_s2   <= (R_W+33)'(x) * (R_W+33)'(RECIP);
		end
	end
endmodule

// ----- src/spin_flip_acceptance_table.sv -----
// Top level of the spin-flip acceptance table: row sequencer, exp pipeline, output register.
//
// Usage: each word on the temperature channel, unsigned Q(24-TEMP_FRAC_BITS).TEMP_FRAC_BITS,
// yields one row of acceptance probabilities (Q1.PROB_FRAC_BITS) on the probability channel,
// one word per entry with entry_index, last and clamped. The square lattice gives
// five entries, the cubic lattice seven, cluster-add mode one.
// Configuration (coupling J, lattice mode) is written through cfg_wr_en / cfg_index /
// cfg_data while no row is in flight.
// Throughput: one entry per cycle while the receiver does not stall, so one new temperature
// per row of five, seven or one entries by mode; the row sequencer issues one entry per
// cycle and takes the next temperature in the cycle that issues the last entry.
// Pipeline stages behind the row sequencer: one issue stage, one range check,
// 35 divider cells, 6 ln2 cells, 14 series cells of 3 stages each, one rounding
// stage and the output register.
// Reset clears the sequencer's busy flag and index, every stage valid and the output
// valid; J resets to 1.0 and the mode to square lattice.
// When the receiver stalls with the output register full, the whole pipeline and the
// sequencer hold; nothing is dropped.
module spin_flip_acceptance_table #(
	parameter int PROB_FRAC_BITS = 16,
	parameter int TEMP_FRAC_BITS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic                      cfg_index,
	input  logic [sfat_pkg::CFG_W-1:0] cfg_data,
	sfat_temp_if.sink                 temp,
	sfat_prob_if.source               prob
);
	import sfat_pkg::*;

	localparam int PW  = PROB_FRAC_BITS + 1;
	localparam int SH  = TEMP_FRAC_BITS + 18;
	localparam int DW  = A_W + SH;
	localparam int HW  = DW - Q_W;
	localparam int CW  = (HW > T_W) ? HW : T_W;
	localparam int EW  = 41;
	localparam logic [6:0] S_OFS = 7'(30 - PROB_FRAC_BITS);
	localparam logic [EW-1:0] ONE_E = EW'(1) << PROB_FRAC_BITS;
	localparam logic [PW-1:0] ONE_P = PW'(1) << PROB_FRAC_BITS;

	// configuration
	logic [CFG_W-1:0] coupling_q;
	logic [1:0]       mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coupling_q <= 16'd4096;
			mode_q     <= '0;
		end else if (cfg_wr_en) begin
			if (cfg_index == REG_COUPLING) begin
				coupling_q <= cfg_data;
			end else if (cfg_index == REG_MODE) begin
				mode_q <= cfg_data[1:0];
			end
		end
	end

	logic adv;
	logic ov_q;
	assign adv = !ov_q || prob.ready;

	// row sequencer
	logic             busy_q;
	logic [IDX_W-1:0] idx_q;
	logic [T_W-1:0]   t_q;
	logic [IDX_W-1:0] last_idx;
	logic             issue;
	logic             take;

	always_comb begin
		if (mode_q[MODE_CLUSTER_BIT]) begin
			last_idx = LAST_CLUSTER;
		end else if (mode_q == MODE_CUBIC) begin
			last_idx = LAST_CUBIC;
		end else begin
			last_idx = LAST_SQUARE;
		end
	end

	assign issue      = busy_q && adv;
	assign temp.ready = adv && (!busy_q || idx_q == last_idx);
	assign take       = temp.valid && temp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (issue) begin
			if (idx_q == last_idx) begin
				busy_q <= 1'b0;
			end else begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			t_q <= temp.temperature;
		end
	end

	// entry setup
	logic signed [CFG_W-1:0] j;
	logic [CFG_W-1:0]        aj;
	logic signed [4:0]       sv;
	logic [3:0]              mag;
	logic                    positive;
	div_t                    iss_nx;
	div_t                    iss_s1;

	always_comb begin
		j  = signed'(coupling_q);
		aj = j[CFG_W-1] ? CFG_W'(-j) : CFG_W'(j);
		sv = (mode_q == MODE_CUBIC) ? SUM_CUBIC[idx_q] : SUM_SQUARE[idx_q];
		mag = sv[4] ? 4'(-sv) : 4'(sv);
		positive = (!j[CFG_W-1] && j != '0 && !sv[4] && sv != '0) ||
			(j[CFG_W-1] && sv[4]);
		iss_nx = '0;
		iss_nx.vld = issue;
		iss_nx.meta.idx = idx_q;
		iss_nx.meta.last = idx_q == last_idx;
		iss_nx.t = t_q;
		if (mode_q[MODE_CLUSTER_BIT]) begin
			iss_nx.meta.cluster = 1'b1;
			iss_nx.a = A_W'(aj) << 1;
			if (j[CFG_W-1]) begin
				iss_nx.meta.fix = FIX_ZERO_CLAMP;
			end else if (j == '0) begin
				iss_nx.meta.fix = FIX_ZERO;
			end else if (t_q == '0) begin
				iss_nx.meta.fix = FIX_ONE;
			end else begin
				iss_nx.meta.fix = FIX_NONE;
			end
		end else begin
			iss_nx.a = A_W'(A_W'(aj) * A_W'(mag));
			if (!positive) begin
				iss_nx.meta.fix = FIX_ONE;
			end else if (t_q == '0) begin
				iss_nx.meta.fix = FIX_ZERO;
			end else begin
				iss_nx.meta.fix = FIX_NONE;
			end
		end
	end

	// range check: quotient of 32.0 or more gives zero
	logic [DW-1:0] d0;
	logic [HW-1:0] hi0;
	div_t          ovf_nx;
	div_t          dv [0:Q_W];

	always_comb begin
		d0  = DW'(iss_s1.a) << SH;
		hi0 = d0[DW-1:Q_W];
		ovf_nx = iss_s1;
		ovf_nx.meta.under = CW'(hi0) >= CW'(iss_s1.t);
		ovf_nx.rem = T_W'(hi0);
		ovf_nx.q = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1 <= '0;
			dv[0]  <= '0;
		end else if (adv) begin
			iss_s1 <= iss_nx;
			dv[0]  <= ovf_nx;
		end
	end

	genvar gi;
	generate
		for (gi = 0; gi < Q_W; gi++) begin : g_div
			logic [DW-1:0] dvec;
			assign dvec = DW'(dv[gi].a) << SH;
			sfat_div_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (adv),
				.din    (dvec[Q_W-1-gi]),
				.d      (dv[gi]),
				.q      (dv[gi+1])
			);
		end
	endgenerate

	ln2_t ln [0:K_W];

	always_comb begin
		ln[0].vld  = dv[Q_W].vld;
		ln[0].meta = dv[Q_W].meta;
		ln[0].y    = dv[Q_W].q;
		ln[0].k    = '0;
	end

	generate
		for (gi = 0; gi < K_W; gi++) begin : g_ln2
			sfat_ln2_cell #(.B(K_W-1-gi)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (adv),
				.d      (ln[gi]),
				.q      (ln[gi+1])
			);
		end
	endgenerate

	term_t tm [0:NTERMS];

	always_comb begin
		tm[0].vld  = ln[K_W].vld;
		tm[0].meta = ln[K_W].meta;
		tm[0].k    = ln[K_W].k;
		tm[0].r    = R_W'(ln[K_W].y);
		tm[0].term = Q30_ONE;
		tm[0].sum  = SUM_W'(Q30_ONE);
	end

	generate
		for (gi = 0; gi < NTERMS; gi++) begin : g_term
			sfat_term_cell #(.N(gi+1)) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.en     (adv),
				.d      (tm[gi]),
				.q      (tm[gi+1])
			);
		end
	endgenerate

	// limit, scale by 2^-k and round
	term_t           fin;
	logic [EW-1:0]   e;
	logic [6:0]      s;
	logic [EW-1:0]   pe;
	logic            fin_vld_s1;
	meta_t           fin_meta_s1;
	logic [PW-1:0]   p_s1;

	always_comb begin
		fin = tm[NTERMS];
		if (fin.sum < 0) begin
			e = '0;
		end else if (fin.sum > SUM_W'(Q30_ONE)) begin
			e = EW'(Q30_ONE);
		end else begin
			e = EW'(fin.sum);
		end
		s = 7'(fin.k) + S_OFS;
		if (s == '0) begin
			pe = e;
		end else if (s > 7'd40) begin
			pe = '0;
		end else begin
			pe = (e + (EW'(1) << (s - 7'd1))) >> s;
		end
		if (pe > ONE_E) begin
			pe = ONE_E;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_vld_s1 <= 1'b0;
		end else if (adv) begin
			fin_vld_s1 <= fin.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fin_meta_s1 <= fin.meta;
			p_s1        <= PW'(pe);
		end
	end

	// output register
	logic [PW-1:0]    pv;
	logic [PW-1:0]    prob_q;
	logic [IDX_W-1:0] oidx_q;
	logic             olast_q;
	logic             oclamp_q;

	always_comb begin
		pv = fin_meta_s1.under ? '0 : p_s1;
		if (fin_meta_s1.cluster) begin
			pv = ONE_P - pv;
		end
		case (fin_meta_s1.fix) inside
			FIX_ONE:                   pv = ONE_P;
			FIX_ZERO, FIX_ZERO_CLAMP:  pv = '0;
			default:                   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (adv) begin
			ov_q <= fin_vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prob_q   <= pv;
			oidx_q   <= fin_meta_s1.idx;
			olast_q  <= fin_meta_s1.last;
			oclamp_q <= fin_meta_s1.fix == FIX_ZERO_CLAMP;
		end
	end

	assign prob.valid       = ov_q;
	assign prob.probability = prob_q;
	assign prob.entry_index = oidx_q;
	assign prob.last        = olast_q;
	assign prob.clamped     = oclamp_q;
endmodule

// ----- tb/tb.sv -----
// Spin-flip acceptance table bench: directed, random rows checked against a fixed-point predictor.
`timescale 1ns / 1ps
module tb;
	import sfat_pkg::*;

	localparam int PROB_FRAC = 16;
	localparam int TEMP_FRAC = 16;
	localparam logic [16:0] PROB_ONE = 17'd65536;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 150;
	localparam logic [1:0] MODE_SQUARE = 2'd0;
	localparam logic [1:0] MODE_CUBE = 2'd1;
	localparam logic [1:0] MODE_CLUSTER = 2'd2;
	localparam logic [1:0] MODE_SPARE = 2'd3;

	typedef struct packed {
		logic [2:0]  entry_index;
		logic [16:0] probability;
		logic        last;
		logic        clamped;
	} entry_t;

	class row_scoreboard;
		entry_t pending[$];
		int errors;
		int entries_seen;

		// exp(-a/t) in Q1.16, t nonzero
		function automatic logic [16:0] exp_neg(logic [63:0] a, logic [63:0] t);
			logic [63:0] y, k, r, p;
			longint term, total;
			int s;
			y = (a << (TEMP_FRAC + 18)) / t;
			if (y >= (64'd32 << 30))
				return '0;
			k = y / 64'd744261118;
			r = y - k * 64'd744261118;
			term = longint'(1) << 30;
			total = term;
			for (int n = 1; n <= 14; n++) begin
				term = longint'((64'(term) * r) >> 30) / n;
				total += (n % 2 == 1) ? -term : term;
			end
			if (total < 0)
				total = 0;
			if (total > (longint'(1) << 30))
				total = longint'(1) << 30;
			s = 30 + int'(k) - PROB_FRAC;
			if (s == 0)
				p = 64'(total);
			else if (s > 40)
				p = 0;
			else
				p = (64'(total) + (64'd1 << (s - 1))) >> s;
			return (p > 64'(PROB_ONE)) ? PROB_ONE : p[16:0];
		endfunction

		function void note_temperature(logic [23:0] t, logic signed [15:0] j, logic [1:0] mode);
			entry_t e;
			logic [63:0] aj;
			int count, sv;
			int sums[7];
			aj = (j < 0) ? 64'(-int'(j)) : 64'(int'(j));
			if (mode[1]) begin
				e = '{3'd0, 17'd0, 1'b1, 1'b0};
				if (j < 0)
					e.clamped = 1'b1;
				else if (j == 0)
					e.probability = 17'd0;
				else if (t == 0)
					e.probability = PROB_ONE;
				else
					e.probability = PROB_ONE - exp_neg(2 * aj, 64'(t));
				pending.push_back(e);
				return;
			end
			if (mode == MODE_CUBE) begin
				sums = '{12, 8, 4, 0, -4, -8, -12};
				count = 7;
			end else begin
				sums = '{8, 4, 0, -4, -8, 0, 0};
				count = 5;
			end
			for (int i = 0; i < count; i++) begin
				sv = sums[i];
				e.entry_index = 3'(i);
				e.last = (i == count - 1);
				e.clamped = 1'b0;
				if (!((j > 0 && sv > 0) || (j < 0 && sv < 0)))
					e.probability = PROB_ONE;
				else if (t == 0)
					e.probability = 17'd0;
				else
					e.probability = exp_neg(aj * 64'((sv < 0) ? -sv : sv), 64'(t));
				pending.push_back(e);
			end
		endfunction

		function void check_entry(entry_t got);
			entry_t want;
			entries_seen++;
			if (pending.size() == 0) begin
				$display("%0t: unexpected entry idx=%0d prob=%0d last=%0b clamped=%0b",
					$time, got.entry_index, got.probability, got.last, got.clamped);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.entry_index !== want.entry_index) begin
				$display("%0t: entry_index expected %0d actual %0d",
					$time, want.entry_index, got.entry_index);
				errors++;
			end
			if (got.probability !== want.probability) begin
				$display("%0t: probability (idx %0d) expected %0d actual %0d",
					$time, want.entry_index, want.probability, got.probability);
				errors++;
			end
			if (got.last !== want.last) begin
				$display("%0t: last expected %0b actual %0b", $time, want.last, got.last);
				errors++;
			end
			if (got.clamped !== want.clamped) begin
				$display("%0t: clamped expected %0b actual %0b",
					$time, want.clamped, got.clamped);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b1;
	logic cfg_wr_en = 1'b0;
	logic cfg_index = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;

	sfat_temp_if temp_ch ();
	sfat_prob_if #(.PROB_W(17)) prob_ch ();

	spin_flip_acceptance_table #(
		.PROB_FRAC_BITS(PROB_FRAC),
		.TEMP_FRAC_BITS(TEMP_FRAC)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.temp(temp_ch.sink),
		.prob(prob_ch.source)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	row_scoreboard rows = new();
	logic signed [15:0] coupling_now = 16'sd4096;
	logic [1:0] mode_now = MODE_SQUARE;
	int temps_sent;
	int idle_cycles;
	bit hold_off;

	initial begin
		temp_ch.valid = 1'b0;
		temp_ch.temperature = '0;
		prob_ch.ready = 1'b0;
		#1 arst_n = 1'b0;
	end

	function automatic int gap_len();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [23:0] rand_temperature();
		case ($urandom_range(0, 5))
			0: return 24'($urandom_range(0, 255));
			1: return 24'($urandom_range(0, 65535));
			2: return 24'($urandom_range(65536, 24'h0A0000));
			3: return 24'hFFFFFF - 24'($urandom_range(0, 1000));
			default: return 24'($urandom);
		endcase
	endfunction

	// hold valid across back-to-back words; drop it only for a gap
	task automatic send_temperature(logic [23:0] t);
		int gap;
		gap = gap_len();
		if (gap != 0) begin
			temp_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		temp_ch.valid <= 1'b1;
		temp_ch.temperature <= t;
		@(posedge clk);
		while (!temp_ch.ready)
			@(posedge clk);
		rows.note_temperature(t, coupling_now, mode_now);
		temps_sent++;
	endtask

	// write only while idle: drain expectations, then give the pipeline time to empty
	task automatic write_config(logic signed [15:0] j, logic [1:0] mode);
		temp_ch.valid <= 1'b0;
		while (rows.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_COUPLING;
		cfg_data <= j;
		@(posedge clk);
		cfg_index <= REG_MODE;
		cfg_data <= CFG_W'(mode);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		coupling_now = j;
		mode_now = mode;
	endtask

	// sink side: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (prob_ch.valid && prob_ch.ready)
			rows.check_entry('{prob_ch.entry_index, prob_ch.probability,
				prob_ch.last, prob_ch.clamped});
	end

	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				prob_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			prob_ch.ready <= 1'b1;
			@(posedge clk);
			gap = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
			if (gap != 0) begin
				prob_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((temp_ch.valid && temp_ch.ready) || (prob_ch.valid && prob_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: watchdog, no progress for %0d cycles", $time, STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic signed [15:0] couplings[8];
		logic [23:0] edge_temps[6];
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset settings, then extreme J in cubic and both cluster modes
		edge_temps = '{24'd0, 24'd1, 24'h010000, 24'hFFFFFF, 24'h800000, 24'h000100};
		foreach (edge_temps[i])
			send_temperature(edge_temps[i]);
		couplings = '{16'sh7FFF, -16'sh8000, 16'sd0, 16'sd1, -16'sd1, 16'sh7FFF,
			-16'sd4096, 16'sd4096};
		write_config(16'sh7FFF, MODE_CUBE);
		send_temperature(24'd0);
		send_temperature(24'd1);
		send_temperature(24'hFFFFFF);
		write_config(-16'sh8000, MODE_CUBE);
		send_temperature(24'd0);
		send_temperature(24'h012345);
		send_temperature(24'hFFFFFF);
		for (int m = 2; m < 4; m++) begin
			foreach (couplings[c]) begin
				if (c > 4)
					break;
				write_config(couplings[c], 2'(m));
				send_temperature(24'd0);
				send_temperature(24'h020000);
			end
		end

		// long receiver hold-off while rows keep coming
		write_config(16'sd4096, MODE_CUBE);
		hold_off = 1'b1;
		repeat (30)
			send_temperature(rand_temperature());

		// random phases
		for (int ph = 0; ph < 11; ph++) begin
			write_config(16'($urandom), 2'($urandom_range(0, 3)));
			repeat (20)
				send_temperature(rand_temperature());
		end
		temp_ch.valid <= 1'b0;

		while (rows.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d temperatures over square, cubic and cluster modes;", temps_sent);
		$display("checked %0d probability entries.", rows.entries_seen);
		if (rows.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule

// ----- sim.f -----
src/sfat_pkg.sv
src/sfat_if.sv
src/sfat_div_cell.sv
src/sfat_ln2_cell.sv
src/sfat_term_cell.sv
src/spin_flip_acceptance_table.sv
tb/tb.sv
